// ===== sv/e2q_pkg.sv =====
// Package for the Euler-angle to quaternion converter.
// Payload structs, CORDIC arctangent table and fixed constants; no dependencies.
package e2q_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } pose_in_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } pose_out_t;

  localparam logic signed [34:0] HalfToTurn = 35'sd2734261102;
  localparam logic signed [34:0] CordicGain = 35'sd652032874;

  typedef logic signed [34:0] cw_t;

  typedef struct packed {
    cw_t x;
    cw_t y;
    cw_t z;
    logic flip;
  } rot_t;

  // rotation state for roll, pitch, yaw
  typedef struct packed {
    rot_t r;
    rot_t p;
    rot_t y;
  } rot3_t;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] t;
    unique case (i)
      0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
      3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
      15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
      21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
      24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
      27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
      30: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

endpackage

// ===== sv/e2q_cell.sv =====
// One CORDIC rotation cell, applied to all three angles in lockstep.
// Registered; uses e2q_pkg.
module e2q_cell #(
  parameter int STAGE = 0
) (
  input  logic            clk,
  input  logic            en,
  input  e2q_pkg::rot3_t  din,
  output e2q_pkg::rot3_t  dout
);
  import e2q_pkg::*;

  localparam cw_t Atan = cw_t'({3'b000, atan_turn(STAGE)});

  function automatic rot_t step(input rot_t a);
    rot_t o;
    cw_t dx;
    cw_t dy;
    o = a;
    dx = a.y >>> STAGE;
    dy = a.x >>> STAGE;
    if (!a.z[34]) begin
      o.x = a.x - dx; o.y = a.y + dy; o.z = a.z - Atan;
    end else begin
      o.x = a.x + dx; o.y = a.y - dy; o.z = a.z + Atan;
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      dout.r <= step(din.r);
      dout.p <= step(din.p);
      dout.y <= step(din.y);
    end
  end
endmodule

// ===== sv/e2q_combine.sv =====
// Quaternion product pipeline: pair products, triple products, sum, round, saturate.
// Three register stages; uses e2q_pkg.
module e2q_combine #(
  parameter int FRAC = 14
) (
  input  logic                 clk,
  input  logic [2:0]           en,
  input  e2q_pkg::cw_t         cr, sr, cp, sp, cy, sy,
  output logic signed [15:0]   qw, qx, qy, qz
);
  import e2q_pkg::*;

  localparam int Sh = 60 - FRAC;

  logic signed [31:0] cc, ss, sc, cs, cy1, sy1;
  logic signed [63:0] p0, p1, p2, p3, p4, p5, p6, p7;

  function automatic logic signed [15:0] quant(input logic signed [63:0] s);
    logic signed [63:0] r;
    logic signed [63:0] one;
    one = 64'sd1 <<< FRAC;
    r = (s + (64'sd1 <<< (Sh - 1))) >>> Sh;
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cc  <= 32'((64'(cr) * 64'(cp)) >>> 30);
      ss  <= 32'((64'(sr) * 64'(sp)) >>> 30);
      sc  <= 32'((64'(sr) * 64'(cp)) >>> 30);
      cs  <= 32'((64'(cr) * 64'(sp)) >>> 30);
      cy1 <= 32'(cy);
      sy1 <= 32'(sy);
    end
    if (en[1]) begin
      p0 <= 64'(cc) * 64'(cy1); p1 <= 64'(ss) * 64'(sy1);
      p2 <= 64'(sc) * 64'(cy1); p3 <= 64'(cs) * 64'(sy1);
      p4 <= 64'(cs) * 64'(cy1); p5 <= 64'(sc) * 64'(sy1);
      p6 <= 64'(cc) * 64'(sy1); p7 <= 64'(ss) * 64'(cy1);
    end
    if (en[2]) begin
      qw <= quant(p0 + p1);
      qx <= quant(p2 - p3);
      qy <= quant(p4 + p5);
      qz <= quant(p6 - p7);
    end
  end
endmodule

// ===== sv/euler_angles_to_quaternion.sv =====
// Euler ZYX roll/pitch/yaw to unit quaternion, with position words passed along.
// One pose per cycle unless stalled. The pipeline is one input stage that folds
// the half angles, a chain of CORDIC_STAGES rotation cells, three product stages
// and an output register. Ready drops only when the output register is full and
// stalled, which freezes the whole chain. Uses e2q_pkg, e2q_cell, e2q_combine.
module euler_angles_to_quaternion #(
  parameter int CORDIC_STAGES = 14,
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  e2q_pkg::pose_in_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output e2q_pkg::pose_out_t  out_data
);
  import e2q_pkg::*;

  localparam int Depth = CORDIC_STAGES + 5;

  logic             adv;
  logic [Depth-1:0] vld;
  rot3_t            chain [CORDIC_STAGES+1];
  logic [95:0]      pos   [Depth-1];
  logic signed [15:0] qw, qx, qy, qz;
  e2q_pkg::cw_t     c_r, s_r, c_p, s_p, c_y, s_y;

  assign adv      = !vld[Depth-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[Depth-1];

  function automatic rot_t fold(input logic signed [15:0] a);
    rot_t o;
    logic signed [50:0] t;
    logic [31:0] u;
    t = (51'(a) * 51'(HalfToTurn)) >>> 16;
    u = t[31:0];
    o.flip = (u + 32'h40000000) >= 32'h80000000;
    if (o.flip) u = u - 32'h80000000;
    o.x = CordicGain;
    o.y = '0;
    o.z = cw_t'($signed(u));
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[Depth-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      chain[0].r <= fold(in_data.roll_angle);
      chain[0].p <= fold(in_data.pitch_angle);
      chain[0].y <= fold(in_data.yaw_angle);
      pos[0] <= {in_data.pos_x, in_data.pos_y, in_data.pos_z};
      for (int i = 1; i < Depth - 1; i++) pos[i] <= pos[i-1];
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    e2q_cell #(.STAGE(g)) u_cell (
      .clk(clk), .en(adv), .din(chain[g]), .dout(chain[g+1])
    );
  end

  function automatic cw_t sgn(input logic f, input cw_t v);
    return f ? -v : v;
  endfunction

  assign c_r = sgn(chain[CORDIC_STAGES].r.flip, chain[CORDIC_STAGES].r.x);
  assign s_r = sgn(chain[CORDIC_STAGES].r.flip, chain[CORDIC_STAGES].r.y);
  assign c_p = sgn(chain[CORDIC_STAGES].p.flip, chain[CORDIC_STAGES].p.x);
  assign s_p = sgn(chain[CORDIC_STAGES].p.flip, chain[CORDIC_STAGES].p.y);
  assign c_y = sgn(chain[CORDIC_STAGES].y.flip, chain[CORDIC_STAGES].y.x);
  assign s_y = sgn(chain[CORDIC_STAGES].y.flip, chain[CORDIC_STAGES].y.y);

  e2q_combine #(.FRAC(QUAT_FRAC_BITS)) u_comb (
    .clk(clk), .en({3{adv}}),
    .cr(c_r), .sr(s_r), .cp(c_p), .sp(s_p), .cy(c_y), .sy(s_y),
    .qw(qw), .qx(qx), .qy(qy), .qz(qz)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      {out_data.out_pos_x, out_data.out_pos_y, out_data.out_pos_z} <= pos[Depth-2];
      out_data.quat_w <= qw;
      out_data.quat_x <= qx;
      out_data.quat_y <= qy;
      out_data.quat_z <= qz;
    end
  end
endmodule
